// ===== src/rvit_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the x^0.14 power table for the variate generator
// no dependencies

package rvit_pkg;

   localparam int LOG_DEPTH       = 8;
   localparam int POW_TABLE_DEPTH = 1 << LOG_DEPTH;
   localparam int LOG_FRAC        = 26;
   localparam int ROOT_BITS       = 32;

   localparam logic [8:0]  NORM_SCALE = 9'd491;
   localparam logic [57:0] NORM_HALF  = 58'd3276800;
   localparam logic [15:0] DIV100_HI  = 16'd41943;
   localparam logic [24:0] RECIP_100  = 25'd21474837;
   localparam logic [16:0] ONE_Q16    = 17'h10000;

   localparam logic [1:0] CSR_CENTRAL_MODE = 2'd0;

   typedef enum logic [1:0] {
      KIND_NORMAL     = 2'd0,
      KIND_TRIANGULAR = 2'd1,
      KIND_UNIFORM    = 2'd2,
      KIND_BAD        = 2'd3
   } kind_type;

   typedef logic [16:0] pow_tab_type [POW_TABLE_DEPTH + 1];

   typedef struct packed {
      logic [16:0] t0;
      logic [16:0] t1;
      logic [15:0] f;
   } pow_pt_type;

   typedef struct packed {
      kind_type           kind;
      logic               central;
      logic               deg;
      logic               upper;
      logic signed [31:0] mn;
      logic signed [31:0] mx;
      logic signed [31:0] md;
      logic signed [31:0] mean;
      logic signed [31:0] nval;
      logic signed [31:0] uval;
   } side_type;

   typedef struct packed {
      logic                   vld;
      logic [35:0]            rem;
      logic [ROOT_BITS-1:0]   root;
      logic [2*ROOT_BITS-1:0] rad;
      side_type               side;
   } sqrt_type;

   function automatic longint log2_fix(input logic [63:0] n);
      int          k;
      logic [63:0] m;
      longint      frac;
      k    = 0;
      m    = '0;
      frac = 0;
      if (n == 64'd0) return 0;
      while (k < 63 && (n >> (k + 1)) != 64'd0) k++;
      if (k <= 31) m = n << (31 - k);
      else m = n >> (k - 31);
      for (int b = LOG_FRAC - 1; b >= 0; b--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | (longint'(1) << b);
            m    = m >> 1;
         end
      end
      return (longint'(k) << LOG_FRAC) + frac;
   endfunction

   function automatic pow_tab_type build_pow_tab();
      pow_tab_type t;
      longint      logd;
      longint      neg;
      longint      a;
      longint      target;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logd = log2_fix(64'(POW_TABLE_DEPTH));
      t[0] = '0;
      t[POW_TABLE_DEPTH] = ONE_Q16;
      for (int i = 1; i < POW_TABLE_DEPTH; i++) begin
         neg    = logd - log2_fix(64'(i));
         a      = (neg * 7 + 25) / 50;
         target = (longint'(30) << LOG_FRAC) - a;
         lo     = 64'd1;
         hi     = 64'd1 << 30;
         while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (log2_fix(mid) <= target) lo = mid;
            else hi = mid - 64'd1;
         end
         t[i] = 17'((lo + 64'd8192) >> 14);
      end
      return t;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

   function automatic pow_pt_type pow_point(input logic [16:0] x);
      logic [16+LOG_DEPTH:0] p;
      logic [LOG_DEPTH:0]    idx;
      pow_pt_type            r;
      p   = {x, {LOG_DEPTH{1'b0}}};
      idx = p[16+LOG_DEPTH:16];
      r.f = p[15:0];
      if (idx[LOG_DEPTH]) begin
         r.t0 = POW_TAB[POW_TABLE_DEPTH];
         r.t1 = POW_TAB[POW_TABLE_DEPTH];
      end else begin
         r.t0 = POW_TAB[idx];
         r.t1 = POW_TAB[idx + 1'b1];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sd2147483647) return 32'sh7fffffff;
      if (v < -38'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

// ===== src/rvit_sqrt_cell.sv =====
`timescale 1ns / 1ps
// one cell of the square root chain: settles one root bit per beat
// depends on rvit_pkg

module rvit_sqrt_cell
   import rvit_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  sqrt_type cell_in,
   output sqrt_type cell_out
);

   sqrt_type    cell_ff;
   sqrt_type    cell_in_nx;
   logic [35:0] sh;
   logic [35:0] trial;
   logic        take;

   always_comb begin
      sh    = {cell_in.rem[33:0], cell_in.rad[2*ROOT_BITS-1 -: 2]};
      trial = {2'b00, cell_in.root, 2'b01};
      take  = (sh >= trial);
      cell_in_nx      = cell_in;
      cell_in_nx.rem  = take ? (sh - trial) : sh;
      cell_in_nx.root = {cell_in.root[ROOT_BITS-2:0], take};
      cell_in_nx.rad  = {cell_in.rad[2*ROOT_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (adv) begin
         cell_ff.vld <= cell_in_nx.vld;
      end
      if (adv) begin
         cell_ff.rem  <= cell_in_nx.rem;
         cell_ff.root <= cell_in_nx.root;
         cell_ff.rad  <= cell_in_nx.rad;
         cell_ff.side <= cell_in_nx.side;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== src/random_variate_inverse_transform.sv =====
`timescale 1ns / 1ps
// inverse transform variate generator: normal, triangular, uniform
// depends on rvit_pkg and rvit_sqrt_cell
// one beat per cycle while no valid result is held by rsp_stall
// the 32-cell square root chain sets the depth; all beats take the same path
// synchronous reset clears valid flags and central_mode; the pipeline holds on stall

module random_variate_inverse_transform
   import rvit_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_dist_kind,
   input  logic [15:0]        req_uniform_sample,
   input  logic signed [31:0] req_mean_value,
   input  logic [30:0]        req_spread,
   input  logic signed [31:0] req_lower_bound,
   input  logic signed [31:0] req_upper_bound,
   input  logic signed [31:0] req_peak_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_variate,
   output logic               rsp_bad_kind,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic adv;
   logic central_ff;
   logic [7:0] vld_ff;
   logic [7:0] vld_in;

   // stage 1
   side_type s1_side_ff;
   logic [15:0] s1_u_ff;
   logic [30:0] s1_sd_ff;
   // stage 2
   side_type s2_side_ff, s2_side_in;
   logic [15:0] s2_u_ff;
   logic [30:0] s2_sd_ff;
   logic [31:0] s2_w_ff, s2_a_ff, s2_c_ff, s2_w_in, s2_a_in, s2_c_in;
   pow_pt_type s2_pa_ff, s2_pb_ff;
   logic signed [32:0] s2_diff_ff, s2_diff_in;
   logic signed [31:0] s2_mdc;
   // stage 3
   side_type s3_side_ff, s3_side_in;
   logic [15:0] s3_u_ff;
   logic [30:0] s3_sd_ff;
   logic [31:0] s3_w_ff, s3_a_ff, s3_c_ff;
   logic [16:0] s3_powa_ff, s3_powb_ff, s3_powa_in, s3_powb_in;
   logic signed [49:0] s3_uprod_ff, s3_uprod_in;
   logic [47:0] s3_uw;
   // stage 4
   side_type s4_side_ff, s4_side_in;
   logic [63:0] s4_p_ff, s4_p_in;
   logic [16:0] s4_wt_ff, s4_wt_in;
   logic [47:0] s4_mag1_ff, s4_mag1_in;
   logic s4_neg_ff, s4_neg_in;
   logic signed [34:0] s4_usum;
   logic signed [17:0] s4_d;
   logic [16:0] s4_dmag;
   // stage 5
   side_type s5_side_ff;
   logic [48:0] s5_ph_ff, s5_pl_ff;
   logic [56:0] s5_m2_ff;
   logic s5_neg_ff;
   // stage 6
   side_type s6_side_ff;
   logic [63:0] s6_rad_ff, s6_rad_in;
   logic [19:0] s6_xh_ff;
   logic [21:0] s6_xl_ff;
   logic s6_neg_ff;
   logic [57:0] s6_t;
   // stage 7
   side_type s7_side_ff;
   logic [63:0] s7_rad_ff;
   logic [35:0] s7_qa_ff;
   logic [22:0] s7_r_ff;
   logic s7_neg_ff;
   // stage 8
   side_type s8_side_ff;
   logic [63:0] s8_rad_ff;
   logic [35:0] s8_qa_ff;
   logic [16:0] s8_qb_ff;
   logic s8_neg_ff;
   logic [47:0] s8_rm;
   // chain
   logic [35:0] s9_q;
   logic signed [37:0] s9_sq;
   sqrt_type chain [ROOT_BITS+1];
   // result
   logic rsp_valid_ff;
   logic signed [31:0] rsp_variate_ff, rsp_variate_in;
   logic rsp_bad_kind_ff, rsp_bad_kind_in;
   side_type fin;
   logic [ROOT_BITS-1:0] fin_root;
   logic signed [32:0] fin_mid;

   assign adv        = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !adv;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_CENTRAL_MODE) ? {31'd0, central_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         central_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_CENTRAL_MODE) begin
         central_ff <= csr_pwdata[0];
      end
   end

   assign vld_in = {vld_ff[6:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= chain[ROOT_BITS].vld;
      end
   end

   // stage 2: bounds, clamp and table lookups
   always_comb begin
      s2_side_in     = s1_side_ff;
      s2_side_in.deg = (s1_side_ff.mx <= s1_side_ff.mn);
      if (s1_side_ff.md < s1_side_ff.mn) s2_mdc = s1_side_ff.mn;
      else if (s1_side_ff.md > s1_side_ff.mx) s2_mdc = s1_side_ff.mx;
      else s2_mdc = s1_side_ff.md;
      s2_diff_in = 33'(s1_side_ff.mx) - 33'(s1_side_ff.mn);
      s2_w_in    = s2_diff_in[31:0];
      s2_a_in    = 32'(33'(s2_mdc) - 33'(s1_side_ff.mn));
      s2_c_in    = 32'(33'(s1_side_ff.mx) - 33'(s2_mdc));
   end

   // stage 3: branch test, interpolation, uniform product
   always_comb begin
      s3_uw            = 48'(s2_u_ff) * 48'(s2_w_ff);
      s3_side_in       = s2_side_ff;
      s3_side_in.upper = (s3_uw >= {s2_a_ff, 16'h0000});
      s3_powa_in = s2_pa_ff.t0 +
                   17'((33'(s2_pa_ff.t1 - s2_pa_ff.t0) * 33'(s2_pa_ff.f)) >> 16);
      s3_powb_in = s2_pb_ff.t0 +
                   17'((33'(s2_pb_ff.t1 - s2_pb_ff.t0) * 33'(s2_pb_ff.f)) >> 16);
      s3_uprod_in = s2_diff_ff * $signed({1'b0, s2_u_ff});
   end

   // stage 4
   always_comb begin
      s4_usum         = 35'(s3_side_ff.mn) + 35'(s3_uprod_ff >>> 16);
      s4_side_in      = s3_side_ff;
      s4_side_in.uval = sat32(38'(s4_usum));
      s4_p_in  = 64'(s3_w_ff) * 64'(s3_side_ff.upper ? s3_c_ff : s3_a_ff);
      s4_wt_in = s3_side_ff.upper ? (ONE_Q16 - {1'b0, s3_u_ff}) : {1'b0, s3_u_ff};
      s4_d      = $signed({1'b0, s3_powa_ff}) - $signed({1'b0, s3_powb_ff});
      s4_neg_in = s4_d[17];
      s4_dmag   = s4_neg_in ? 17'(-s4_d) : s4_d[16:0];
      s4_mag1_in = 48'(s3_sd_ff) * 48'(s4_dmag);
   end

   always_comb begin
      s6_t      = 58'(s5_m2_ff) + NORM_HALF;
      s6_rad_in = 64'((65'(s5_ph_ff) << 16) + 65'(s5_pl_ff >> 16));
      s8_rm     = 48'(s7_r_ff) * 48'(RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff.kind    <= kind_type'(req_dist_kind);
         s1_side_ff.central <= central_ff;
         s1_side_ff.deg     <= 1'b0;
         s1_side_ff.upper   <= 1'b0;
         s1_side_ff.mn      <= req_lower_bound;
         s1_side_ff.mx      <= req_upper_bound;
         s1_side_ff.md      <= req_peak_value;
         s1_side_ff.mean    <= req_mean_value;
         s1_side_ff.nval    <= '0;
         s1_side_ff.uval    <= '0;
         s1_u_ff            <= req_uniform_sample;
         s1_sd_ff           <= req_spread;

         s2_side_ff <= s2_side_in;
         s2_u_ff    <= s1_u_ff;
         s2_sd_ff   <= s1_sd_ff;
         s2_w_ff    <= s2_w_in;
         s2_a_ff    <= s2_a_in;
         s2_c_ff    <= s2_c_in;
         s2_diff_ff <= s2_diff_in;
         s2_pa_ff   <= pow_point({1'b0, s1_u_ff});
         s2_pb_ff   <= pow_point(ONE_Q16 - {1'b0, s1_u_ff});

         s3_side_ff  <= s3_side_in;
         s3_u_ff     <= s2_u_ff;
         s3_sd_ff    <= s2_sd_ff;
         s3_w_ff     <= s2_w_ff;
         s3_a_ff     <= s2_a_ff;
         s3_c_ff     <= s2_c_ff;
         s3_powa_ff  <= s3_powa_in;
         s3_powb_ff  <= s3_powb_in;
         s3_uprod_ff <= s3_uprod_in;

         s4_side_ff <= s4_side_in;
         s4_p_ff    <= s4_p_in;
         s4_wt_ff   <= s4_wt_in;
         s4_mag1_ff <= s4_mag1_in;
         s4_neg_ff  <= s4_neg_in;

         s5_side_ff <= s4_side_ff;
         s5_ph_ff   <= 49'(s4_p_ff[63:32]) * 49'(s4_wt_ff);
         s5_pl_ff   <= 49'(s4_p_ff[31:0]) * 49'(s4_wt_ff);
         s5_m2_ff   <= 57'(s4_mag1_ff) * 57'(NORM_SCALE);
         s5_neg_ff  <= s4_neg_ff;

         s6_side_ff <= s5_side_ff;
         s6_rad_ff  <= s6_rad_in;
         s6_xh_ff   <= s6_t[57:38];
         s6_xl_ff   <= s6_t[37:16];
         s6_neg_ff  <= s5_neg_ff;

         // x / 100 with x = xh * 2^22 + xl and 2^22 = 41943 * 100 + 4
         s7_side_ff <= s6_side_ff;
         s7_rad_ff  <= s6_rad_ff;
         s7_qa_ff   <= 36'(s6_xh_ff) * 36'(DIV100_HI);
         s7_r_ff    <= 23'({s6_xh_ff, 2'b00}) + 23'(s6_xl_ff);
         s7_neg_ff  <= s6_neg_ff;

         s8_side_ff <= s7_side_ff;
         s8_rad_ff  <= s7_rad_ff;
         s8_qa_ff   <= s7_qa_ff;
         s8_qb_ff   <= s8_rm[47:31];
         s8_neg_ff  <= s7_neg_ff;
      end
   end

   always_comb begin
      s9_q  = s8_qa_ff + 36'(s8_qb_ff);
      s9_sq = $signed({2'b00, s9_q});
      chain[0].vld  = vld_ff[7];
      chain[0].rem  = '0;
      chain[0].root = '0;
      chain[0].rad  = s8_rad_ff;
      chain[0].side = s8_side_ff;
      chain[0].side.nval = sat32(38'(s8_side_ff.mean) + (s8_neg_ff ? -s9_sq : s9_sq));
   end

   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_root
      rvit_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   always_comb begin
      fin      = chain[ROOT_BITS].side;
      fin_root = chain[ROOT_BITS].root;
      fin_mid  = (33'(fin.mn) + 33'(fin.mx)) >>> 1;
      rsp_bad_kind_in = 1'b0;
      case (fin.kind)
         KIND_NORMAL: begin
            rsp_variate_in = fin.central ? fin.mean : fin.nval;
         end
         KIND_TRIANGULAR: begin
            if (fin.central) rsp_variate_in = fin.md;
            else if (fin.deg) rsp_variate_in = fin.mn;
            else if (fin.upper) rsp_variate_in = 32'(34'(fin.mx) - 34'(fin_root));
            else rsp_variate_in = 32'(34'(fin.mn) + 34'(fin_root));
         end
         KIND_UNIFORM: begin
            rsp_variate_in = fin.central ? fin_mid[31:0] : fin.uval;
         end
         default: begin
            rsp_variate_in  = '0;
            rsp_bad_kind_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_variate_ff  <= rsp_variate_in;
         rsp_bad_kind_ff <= rsp_bad_kind_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_variate  = rsp_variate_ff;
   assign rsp_bad_kind = rsp_bad_kind_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_kind_ff |-> rsp_variate_ff == 32'sd0)
      else $error("bad kind beat with nonzero variate");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(chain[ROOT_BITS]))
      else $error("root chain moved during stall");

endmodule

// ===== tb/sv/tb_random_variate_inverse_transform.sv =====
`timescale 1ns / 1ps
// self-checking bench for random_variate_inverse_transform: random and directed
// beats with stalls, central mode toggled between phases; own variate predictor
// depends on rvit_pkg and the block rtl

module tb_random_variate_inverse_transform;
   import rvit_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] u;
      longint      mean;
      longint      sd;
      longint      mn;
      longint      mx;
      longint      md;
   } sample_req_type;

   typedef struct {
      logic signed [31:0] variate;
      logic               bad;
   } variate_type;

   // x^0.14 table built independently with integer log2 and bisection
   longint power_tab [0:256];
   bit     central;

   function automatic longint lg2(longint unsigned n);
      int              k;
      longint unsigned m;
      longint          fr;
      k  = 0;
      fr = 0;
      if (n == 0) return 0;
      while (k < 63 && (n >> (k + 1)) != 0) k++;
      m = (k <= 31) ? (n << (31 - k)) : (n >> (k - 31));
      for (int b = 25; b >= 0; b--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            fr = fr | (longint'(1) << b);
            m  = m >> 1;
         end
      end
      return (longint'(k) << 26) + fr;
   endfunction

   task automatic fill_power_tab();
      longint ld;
      longint a;
      longint tgt;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      ld = lg2(256);
      power_tab[0]   = 0;
      power_tab[256] = 65536;
      for (int i = 1; i < 256; i++) begin
         a   = ((ld - lg2(i)) * 7 + 25) / 50;
         tgt = (longint'(30) << 26) - a;
         lo  = 1;
         hi  = 64'd1 << 30;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (lg2(mid) <= tgt) lo = mid;
            else hi = mid - 1;
         end
         power_tab[i] = longint'((lo + 8192) >> 14);
      end
   endtask

   function automatic longint pow014(longint x);
      longint p;
      longint i;
      longint f;
      p = x * 256;
      i = p >>> 16;
      f = p & 16'hffff;
      if (i >= 256) return power_tab[256];
      return power_tab[i] + (((power_tab[i + 1] - power_tab[i]) * f) >>> 16);
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else r = r >> 1;
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mul_q16(longint unsigned p, longint unsigned w);
      return (((p >> 32) * w) << 16) + (((p & 64'hffff_ffff) * w) >> 16);
   endfunction

   function automatic variate_type predict_variate(sample_req_type s);
      variate_type     r;
      longint          v;
      longint          u;
      longint          d;
      longint          prod;
      longint          q;
      longint          md;
      longint unsigned aa;
      longint unsigned ww;
      longint unsigned cc;
      longint unsigned mag;
      u     = s.u;
      v     = 0;
      r.bad = 1'b0;
      case (kind_type'(s.kind))
         KIND_NORMAL: begin
            if (central) v = s.mean;
            else begin
               d    = pow014(u) - pow014(65536 - u);
               prod = s.sd * d * 491;
               mag  = (prod < 0) ? -prod : prod;
               q    = longint'((mag + 3276800) / 6553600);
               if (prod < 0) q = -q;
               v = clip32(s.mean + q);
            end
         end
         KIND_TRIANGULAR: begin
            if (central) v = s.md;
            else if (s.mx <= s.mn) v = s.mn;
            else begin
               md = s.md;
               if (md < s.mn) md = s.mn;
               if (md > s.mx) md = s.mx;
               aa = md - s.mn;
               ww = s.mx - s.mn;
               cc = s.mx - md;
               if (longint'(u) * ww >= (aa << 16))
                  v = s.mx - longint'(root_floor(mul_q16(ww * cc, 65536 - u)));
               else v = s.mn + longint'(root_floor(mul_q16(aa * ww, u)));
            end
         end
         KIND_UNIFORM: begin
            if (central) v = (s.mn + s.mx) >>> 1;
            else v = clip32(s.mn + (((s.mx - s.mn) * u) >>> 16));
         end
         default: r.bad = 1'b1;
      endcase
      r.variate = 32'(clip32(v));
      return r;
   endfunction

   class variate_board;
      variate_type pending[$];
      int          errors;
      int          checked;

      function void note_sample(variate_type e);
         pending.push_back(e);
      endfunction

      function void check_beat(logic signed [31:0] v, logic b);
         variate_type e;
         if (pending.size() == 0) begin
            $error("result beat with nothing pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (v !== e.variate) begin
            $error("variate: expected %0d, got %0d", e.variate, v);
            errors++;
         end
         if (b !== e.bad) begin
            $error("bad_kind: expected %0b, got %0b", e.bad, b);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_dist_kind;
   logic [15:0]        req_uniform_sample;
   logic signed [31:0] req_mean_value;
   logic [30:0]        req_spread;
   logic signed [31:0] req_lower_bound;
   logic signed [31:0] req_upper_bound;
   logic signed [31:0] req_peak_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_variate;
   logic               rsp_bad_kind;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [1:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   variate_board board;
   bit           sending_done;
   int           kind_count [4];

   random_variate_inverse_transform u_top (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_random_variate_inverse_transform: FAIL");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic longint rand32();
      case ($urandom_range(0, 5))
         0: return -64'sd2147483648;
         1: return 64'sd2147483647;
         2: return longint'($signed(32'($urandom_range(0, 400000)) - 32'sd200000));
         default: return longint'($signed($urandom()));
      endcase
   endfunction

   // receiver: stall runs of random length, checks every result beat
   initial begin
      int hold;
      hold      = 0;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) board.check_beat(rsp_variate, rsp_bad_kind);
         if (hold > 0 && !sending_done) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
            hold = ($urandom_range(0, 99) < 70) ? 0 : gap_len();
         end
      end
   end

   task automatic send_sample(sample_req_type s);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_dist_kind      <= s.kind;
      req_uniform_sample <= s.u;
      req_mean_value     <= 32'(s.mean);
      req_spread         <= 31'(s.sd);
      req_lower_bound    <= 32'(s.mn);
      req_upper_bound    <= 32'(s.mx);
      req_peak_value     <= 32'(s.md);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(predict_variate(s));
      kind_count[s.kind]++;
   endtask

   task automatic write_central(bit val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_CENTRAL_MODE;
      csr_pwdata  <= {31'd0, val};
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      central = val;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic sample_req_type random_sample();
      sample_req_type s;
      s.kind = 2'($urandom_range(0, 99) < 95 ? $urandom_range(0, 2) : 3);
      s.u    = 16'($urandom());
      if ($urandom_range(0, 9) == 0) s.u = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      s.mean = rand32();
      s.sd   = $urandom_range(0, 3) == 0 ? longint'($urandom() & 32'h7fffffff)
                                         : longint'($urandom_range(0, 20 << 16));
      s.mn   = rand32();
      s.mx   = rand32();
      s.md   = rand32();
      // mostly well-ordered bounds so the triangular branches are exercised
      if ($urandom_range(0, 9) < 8) begin
         if (s.mn > s.mx) begin
            longint t;
            t = s.mn; s.mn = s.mx; s.mx = t;
         end
         if ($urandom_range(0, 9) < 8 && s.mx > s.mn)
            s.md = s.mn + longint'($urandom()) % (s.mx - s.mn + 1);
      end
      return s;
   endfunction

   function automatic sample_req_type make_req(logic [1:0] k, logic [15:0] u, longint mean,
                                               longint sd, longint mn, longint mx,
                                               longint md);
      sample_req_type s;
      s.kind = k; s.u = u; s.mean = mean; s.sd = sd; s.mn = mn; s.mx = mx; s.md = md;
      return s;
   endfunction

   initial begin
      sample_req_type dir[$];
      longint         lo32;
      longint         hi32;
      lo32 = -64'sd2147483648;
      hi32 = 64'sd2147483647;
      board = new();
      fill_power_tab();
      central            = 1'b0;
      sending_done       = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_dist_kind      = '0;
      req_uniform_sample = '0;
      req_mean_value     = '0;
      req_spread         = '0;
      req_lower_bound    = '0;
      req_upper_bound    = '0;
      req_peak_value     = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir.push_back(make_req(KIND_NORMAL, 16'h0000, 0, 1 << 16, 0, 0, 0));
      dir.push_back(make_req(KIND_NORMAL, 16'hffff, 0, 1 << 16, 0, 0, 0));
      dir.push_back(make_req(KIND_NORMAL, 16'h8000, 5 << 16, 3 << 16, 0, 0, 0));
      dir.push_back(make_req(KIND_NORMAL, 16'hffff, hi32, 31'h7fffffff, 0, 0, 0));
      dir.push_back(make_req(KIND_NORMAL, 16'h0000, lo32, 31'h7fffffff, 0, 0, 0));
      dir.push_back(make_req(KIND_NORMAL, 16'h1234, -1, 0, 0, 0, 0));
      dir.push_back(make_req(KIND_TRIANGULAR, 16'h4000, 0, 0, 0, 10 << 16, 3 << 16));
      dir.push_back(make_req(KIND_TRIANGULAR, 16'hc000, 0, 0, 0, 10 << 16, 3 << 16));
      dir.push_back(make_req(KIND_TRIANGULAR, 16'h8000, 0, 0, 7, 7, 9));
      dir.push_back(make_req(KIND_TRIANGULAR, 16'h8000, 0, 0, 9, 3, 5));
      dir.push_back(make_req(KIND_TRIANGULAR, 16'h8000, 0, 0, 0, 100, -50));
      dir.push_back(make_req(KIND_TRIANGULAR, 16'h8000, 0, 0, 0, 100, 500));
      dir.push_back(make_req(KIND_TRIANGULAR, 16'hffff, 0, 0, lo32, hi32, 0));
      dir.push_back(make_req(KIND_TRIANGULAR, 16'h0000, 0, 0, lo32, hi32, hi32));
      dir.push_back(make_req(KIND_UNIFORM, 16'h0000, 0, 0, lo32, hi32, 0));
      dir.push_back(make_req(KIND_UNIFORM, 16'hffff, 0, 0, lo32, hi32, 0));
      dir.push_back(make_req(KIND_UNIFORM, 16'hffff, 0, 0, hi32, lo32, 0));
      dir.push_back(make_req(KIND_UNIFORM, 16'h8000, 0, 0, -3, 4, 0));
      dir.push_back(make_req(KIND_BAD, 16'hffff, hi32, 31'h7fffffff, lo32, hi32, -1));
      foreach (dir[i]) send_sample(dir[i]);
      drain();

      write_central(1'b1);
      foreach (dir[i]) send_sample(dir[i]);
      for (int i = 0; i < 100; i++) send_sample(random_sample());
      drain();

      write_central(1'b0);
      for (int i = 0; i < 1300; i++) send_sample(random_sample());
      drain();

      write_central(1'b1);
      for (int i = 0; i < 150; i++) send_sample(random_sample());
      drain();

      write_central(1'b0);
      for (int i = 0; i < 200; i++) send_sample(random_sample());
      sending_done = 1'b1;
      drain();

      $display("checked %0d results: normal %0d, triangular %0d, uniform %0d, invalid %0d",
               board.checked, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
      $display("central mode toggled across five phases with random stalls on both sides");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_random_variate_inverse_transform: PASS");
      else
         $display("tb_random_variate_inverse_transform: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/rvit_pkg.sv
src/rvit_sqrt_cell.sv
src/random_variate_inverse_transform.sv
tb/sv/tb_random_variate_inverse_transform.sv
